// File: rtl/wavhp_pkg.sv
// Package for the WAV chunk header parser: parse state, beat and result types,
// phase codes, item kinds, error codes and RIFF constants.
// Depends on nothing; used by the interfaces, wavhp_core and the top level.
package wavhp_pkg;

    typedef enum logic [5:0] {
        PH_SKIP_RIFF = 6'b000001,
        PH_HEADER    = 6'b000010,
        PH_SKIP_BODY = 6'b000100,
        PH_FMT_BODY  = 6'b001000,
        PH_DATA      = 6'b010000,
        PH_DONE      = 6'b100000
    } t_phase;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_FMT    = 3'd1;
    localparam logic [2:0] ERR_FMT_SHORT = 3'd2;
    localparam logic [2:0] ERR_BAD_FMT   = 3'd3;
    localparam logic [2:0] ERR_NO_DATA   = 3'd4;

    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;   // "fmt "
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;   // "data"

    localparam logic [31:0] RIFF_LAST_IDX   = 32'd11;   // 12-byte descriptor
    localparam logic [31:0] FMT_MIN_LEN     = 32'd16;
    localparam logic [15:0] FMT_PCM         = 16'h0001;
    localparam logic [15:0] FMT_EXTENSIBLE  = 16'hFFFE;
    localparam logic [3:0]  CHUNK_LIMIT_RST = 4'd10;
    localparam logic [3:0]  CHUNKS_MAX      = 4'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
        logic       file_end;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        format_valid;
        logic [15:0] format_code;
        logic [15:0] channel_count;
        logic [31:0] sampling_rate;
        logic [15:0] sample_bits;
        logic [2:0]  error_code;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] byte_index;
        logic [31:0] chunk_tag;
        logic [31:0] chunk_length;
        logic [3:0]  chunks_seen;
        logic        fmt_seen;
        logic        fmt_done;
        logic [15:0] fmt_format;
        logic [15:0] fmt_channels;
        logic [31:0] fmt_rate;
        logic [15:0] fmt_bits;
        logic        finished;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{
        phase:        PH_SKIP_RIFF,
        byte_index:   32'd0,
        chunk_tag:    32'd0,
        chunk_length: 32'd0,
        chunks_seen:  4'd0,
        fmt_seen:     1'b0,
        fmt_done:     1'b0,
        fmt_format:   16'd0,
        fmt_channels: 16'd0,
        fmt_rate:     32'd0,
        fmt_bits:     16'd0,
        finished:     1'b0
    };

endpackage

// File: rtl/wavhp_in_if.sv
// Input byte channel of the WAV chunk header parser.
// Depends on wavhp_pkg.
interface wavhp_in_if import wavhp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;

    modport source (output valid, output data_byte, output file_start, output file_end,
                    input ready);
    modport sink (input valid, input data_byte, input file_start, input file_end,
                  output ready);
endinterface

// File: rtl/wavhp_out_if.sv
// Result channel of the WAV chunk header parser.
// Depends on wavhp_pkg.
interface wavhp_out_if import wavhp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        format_valid;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sampling_rate;
    logic [15:0] sample_bits;
    logic [2:0]  error_code;

    modport source (output valid, output item_kind, output payload_byte,
                    output payload_last, output format_valid, output format_code,
                    output channel_count, output sampling_rate, output sample_bits,
                    output error_code, input ready);
    modport sink (input valid, input item_kind, input payload_byte,
                  input payload_last, input format_valid, input format_code,
                  input channel_count, input sampling_rate, input sample_bits,
                  input error_code, output ready);
endinterface

// File: rtl/wavhp_cfg_if.sv
// Configuration write channel of the WAV chunk header parser (chunk limit).
// Depends on wavhp_pkg.
interface wavhp_cfg_if import wavhp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [3:0] chunk_limit;

    modport source (output valid, output chunk_limit, input ready);
    modport sink (input valid, input chunk_limit, output ready);
endinterface

// File: rtl/wavhp_core.sv
// Parse state registers and the per-byte update of the WAV chunk walker.
// Depends on wavhp_pkg.
module wavhp_core import wavhp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_in_beat   i_beat,
    input  logic [3:0] i_chunk_limit,
    output t_result    o_result
);

    t_parse r_st;
    t_parse n_st;

    t_parse      s;
    logic [2:0]  k;
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [7:0]  pb;
    logic        last;
    logic [32:0] idx_inc;
    logic [32:0] padded;

    always_comb begin
        s       = i_beat.file_start ? PARSE_CLEAR : r_st;
        n_st    = s;
        kind    = KIND_HEADER;
        err     = ERR_NONE;
        pb      = 8'd0;
        last    = 1'b0;
        k       = s.byte_index[2:0];
        idx_inc = {1'b0, s.byte_index} + 33'd1;
        padded  = {1'b0, s.chunk_length} + {32'd0, s.chunk_length[0]};

        if (s.finished) begin
            kind = KIND_IGNORED;
        end else begin
            case (s.phase)
                PH_SKIP_RIFF: begin
                    if (s.byte_index >= RIFF_LAST_IDX) begin
                        n_st.phase      = PH_HEADER;
                        n_st.byte_index = 32'd0;
                    end else begin
                        n_st.byte_index = idx_inc[31:0];
                    end
                end
                PH_HEADER: begin
                    // ID big-endian into the tag, length little-endian
                    if (k == 3'd0) begin
                        n_st.chunk_tag    = {24'd0, i_beat.data_byte};
                        n_st.chunk_length = 32'd0;
                    end else if (k < 3'd4) begin
                        n_st.chunk_tag = {s.chunk_tag[23:0], i_beat.data_byte};
                    end else begin
                        case (k[1:0])
                            2'd0:    n_st.chunk_length[7:0]   = i_beat.data_byte;
                            2'd1:    n_st.chunk_length[15:8]  = i_beat.data_byte;
                            2'd2:    n_st.chunk_length[23:16] = i_beat.data_byte;
                            default: n_st.chunk_length[31:24] = i_beat.data_byte;
                        endcase
                    end
                    if (k == 3'd7) begin
                        n_st.byte_index = 32'd0;
                        if (s.chunks_seen != CHUNKS_MAX) begin
                            n_st.chunks_seen = s.chunks_seen + 4'd1;
                        end
                        if (n_st.chunk_tag == TAG_DATA) begin
                            if (!s.fmt_seen) begin
                                err = ERR_NO_FMT;
                            end else if (n_st.chunk_length == 32'd0) begin
                                n_st.finished = 1'b1;
                            end else begin
                                n_st.phase = PH_DATA;
                            end
                        end else begin
                            if (n_st.chunk_tag == TAG_FMT && !s.fmt_seen) begin
                                n_st.fmt_seen = 1'b1;
                                if (n_st.chunk_length < FMT_MIN_LEN) begin
                                    err = ERR_FMT_SHORT;
                                end else begin
                                    n_st.phase = PH_FMT_BODY;
                                end
                            end else if (n_st.chunk_length != 32'd0) begin
                                n_st.phase = PH_SKIP_BODY;
                            end
                            if (err == ERR_NONE && n_st.chunks_seen >= i_chunk_limit) begin
                                err = n_st.fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
                            end
                        end
                    end else begin
                        n_st.byte_index = {29'd0, k} + 32'd1;
                    end
                end
                PH_SKIP_BODY, PH_FMT_BODY: begin
                    if (s.phase == PH_FMT_BODY) begin
                        case (s.byte_index)
                            32'd0:  n_st.fmt_format = {8'd0, i_beat.data_byte};
                            32'd1: begin
                                n_st.fmt_format[15:8] = i_beat.data_byte;
                                if (n_st.fmt_format != FMT_PCM &&
                                    n_st.fmt_format != FMT_EXTENSIBLE) begin
                                    err = ERR_BAD_FMT;
                                end
                            end
                            32'd2:  n_st.fmt_channels = {8'd0, i_beat.data_byte};
                            32'd3:  n_st.fmt_channels[15:8] = i_beat.data_byte;
                            32'd4:  n_st.fmt_rate = {24'd0, i_beat.data_byte};
                            32'd5:  n_st.fmt_rate[15:8] = i_beat.data_byte;
                            32'd6:  n_st.fmt_rate[23:16] = i_beat.data_byte;
                            32'd7:  n_st.fmt_rate[31:24] = i_beat.data_byte;
                            32'd14: n_st.fmt_bits = {8'd0, i_beat.data_byte};
                            32'd15: begin
                                n_st.fmt_bits[15:8] = i_beat.data_byte;
                                n_st.fmt_done       = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    // body padded to even length
                    if (idx_inc >= padded) begin
                        n_st.phase      = PH_HEADER;
                        n_st.byte_index = 32'd0;
                    end else begin
                        n_st.byte_index = idx_inc[31:0];
                    end
                end
                PH_DATA: begin
                    kind = KIND_PAYLOAD;
                    pb   = i_beat.data_byte;
                    if (idx_inc >= {1'b0, s.chunk_length}) begin
                        last          = 1'b1;
                        n_st.finished = 1'b1;
                    end else begin
                        n_st.byte_index = idx_inc[31:0];
                    end
                end
                default: begin
                    n_st.finished = 1'b1;
                    kind          = KIND_IGNORED;
                end
            endcase
        end

        // early end loses to an error found on this byte
        if (err == ERR_NONE && i_beat.file_end && !n_st.finished) begin
            err = (n_st.phase == PH_DATA || n_st.fmt_seen) ? ERR_NO_DATA : ERR_NO_FMT;
        end
        if (err != ERR_NONE) begin
            kind          = KIND_ERROR;
            pb            = 8'd0;
            last          = 1'b0;
            n_st.finished = 1'b1;
        end
        if (n_st.finished) begin
            n_st.phase = PH_DONE;
        end

        o_result.item_kind     = kind;
        o_result.payload_byte  = pb;
        o_result.payload_last  = last;
        o_result.format_valid  = n_st.fmt_done;
        o_result.format_code   = n_st.fmt_format;
        o_result.channel_count = n_st.fmt_channels;
        o_result.sampling_rate = n_st.fmt_rate;
        o_result.sample_bits   = n_st.fmt_bits;
        o_result.error_code    = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= PARSE_CLEAR;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

endmodule

// File: rtl/wav_chunk_header_parser.sv
// Top level of the WAV chunk header parser: input register, result register,
// chunk limit register. Depends on wavhp_pkg, the three channel interfaces and wavhp_core.
//
// Usage: feed a WAV file one byte per beat on i_in, with file_start on its
// first byte and file_end on its last. Every input beat yields exactly one
// result beat on o_out: a header byte, a payload byte of the data chunk
// (payload_last on its final byte), an error with its code, or an ignored
// byte once the parse has finished. The captured fmt fields ride along on
// every result beat. i_cfg writes the chunk limit (reset value 10); write it
// only while no beats are in flight.
// An input beat passes the input register, then the result register;
// throughput is one byte per cycle while o_out does not stall, set by the
// combinational parse update between them. The input register frees as
// soon as its byte moves on, so a new beat is taken while a result waits.
// Reset clears the parse state and both valid flags and sets the chunk limit
// back to 10.
// A stall on o_out holds the result register, then the input register, and
// then drops i_in.ready; nothing is lost or repeated.
module wav_chunk_header_parser import wavhp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wavhp_in_if.sink  i_in,
    wavhp_cfg_if.sink i_cfg,
    wavhp_out_if.source o_out
);

    t_in_beat   r_in;
    logic       r_in_valid;
    t_result    r_out;
    logic       r_out_valid;
    logic [3:0] r_chunk_limit;

    t_result    core_result;
    logic       advance;
    logic       in_take;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    wavhp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_beat        (r_in),
        .i_chunk_limit (r_chunk_limit),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_chunk_limit <= CHUNK_LIMIT_RST;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_chunk_limit <= i_cfg.chunk_limit;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.data_byte  <= i_in.data_byte;
            r_in.file_start <= i_in.file_start;
            r_in.file_end   <= i_in.file_end;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.item_kind     = r_out.item_kind;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.payload_last  = r_out.payload_last;
    assign o_out.format_valid  = r_out.format_valid;
    assign o_out.format_code   = r_out.format_code;
    assign o_out.channel_count = r_out.channel_count;
    assign o_out.sampling_rate = r_out.sampling_rate;
    assign o_out.sample_bits   = r_out.sample_bits;
    assign o_out.error_code    = r_out.error_code;

endmodule

// File: tb/sv/wav_chunk_header_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for wav_chunk_header_parser: drives whole WAV files byte by byte,
// predicts every result beat in a scoreboard class and compares it field by field.
// Depends on wavhp_pkg, the three channel interfaces and the parser RTL.
module wav_chunk_header_parser_tb import wavhp_pkg::*; ();

    // Tracks the parse as the block should see it and holds the results still to come.
    class wav_parse_board;
        logic [3:0]  chunk_limit;
        t_phase      cur_phase;
        logic [31:0] byte_index;
        logic [31:0] chunk_tag;
        logic [31:0] chunk_length;
        logic [3:0]  chunks_seen;
        logic        fmt_seen;
        logic        fmt_done;
        logic [15:0] fmt_format;
        logic [15:0] fmt_channels;
        logic [31:0] fmt_rate;
        logic [15:0] fmt_bits;
        logic        finished;
        t_result     due_results[$];
        int          mismatch_count;

        function new();
            chunk_limit    = CHUNK_LIMIT_RST;
            mismatch_count = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            cur_phase    = PH_SKIP_RIFF;
            byte_index   = '0;
            chunk_tag    = '0;
            chunk_length = '0;
            chunks_seen  = '0;
            fmt_seen     = 1'b0;
            fmt_done     = 1'b0;
            fmt_format   = '0;
            fmt_channels = '0;
            fmt_rate     = '0;
            fmt_bits     = '0;
            finished     = 1'b0;
        endfunction

        function void set_chunk_limit(logic [3:0] value);
            chunk_limit = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Advance the parse by one accepted byte and queue the result it causes.
        function void parse_byte(t_in_beat beat);
            logic [7:0]  b;
            logic [2:0]  k;
            logic [32:0] padded;
            logic [1:0]  kind;
            logic [2:0]  err;
            logic [7:0]  pb;
            logic        last;
            t_result     r;
            b    = beat.data_byte;
            kind = KIND_HEADER;
            err  = ERR_NONE;
            pb   = 8'd0;
            last = 1'b0;
            if (beat.file_start) clear_parse();
            if (finished) begin
                kind = KIND_IGNORED;
            end else begin
                case (cur_phase)
                    PH_SKIP_RIFF: begin
                        if (byte_index >= RIFF_LAST_IDX) begin
                            cur_phase  = PH_HEADER;
                            byte_index = '0;
                        end else begin
                            byte_index = byte_index + 1;
                        end
                    end
                    PH_HEADER: begin
                        k = byte_index[2:0];
                        if (k == 3'd0) begin
                            chunk_tag    = {24'd0, b};
                            chunk_length = '0;
                        end else if (k < 3'd4) begin
                            chunk_tag = {chunk_tag[23:0], b};
                        end else begin
                            chunk_length = chunk_length | ({24'd0, b} << (8 * (k - 3'd4)));
                        end
                        if (k == 3'd7) begin
                            byte_index = '0;
                            if (chunks_seen < CHUNKS_MAX) chunks_seen = chunks_seen + 4'd1;
                            if (chunk_tag == TAG_DATA) begin
                                if (!fmt_seen) err = ERR_NO_FMT;
                                else if (chunk_length == 0) finished = 1'b1;
                                else cur_phase = PH_DATA;
                            end else begin
                                if (chunk_tag == TAG_FMT && !fmt_seen) begin
                                    fmt_seen = 1'b1;
                                    if (chunk_length < FMT_MIN_LEN) err = ERR_FMT_SHORT;
                                    else cur_phase = PH_FMT_BODY;
                                end else if (chunk_length != 0) begin
                                    cur_phase = PH_SKIP_BODY;
                                end
                                if (err == ERR_NONE && chunks_seen >= chunk_limit)
                                    err = fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
                            end
                        end else begin
                            byte_index = {29'd0, k} + 1;
                        end
                    end
                    PH_SKIP_BODY, PH_FMT_BODY: begin
                        if (cur_phase == PH_FMT_BODY) begin
                            case (byte_index)
                                0: fmt_format = {8'd0, b};
                                1: begin
                                    fmt_format = fmt_format | {b, 8'd0};
                                    if (fmt_format != FMT_PCM && fmt_format != FMT_EXTENSIBLE)
                                        err = ERR_BAD_FMT;
                                end
                                2: fmt_channels = {8'd0, b};
                                3: fmt_channels = fmt_channels | {b, 8'd0};
                                4: fmt_rate = {24'd0, b};
                                5: fmt_rate = fmt_rate | {16'd0, b, 8'd0};
                                6: fmt_rate = fmt_rate | {8'd0, b, 16'd0};
                                7: fmt_rate = fmt_rate | {b, 24'd0};
                                14: fmt_bits = {8'd0, b};
                                15: begin
                                    fmt_bits = fmt_bits | {b, 8'd0};
                                    fmt_done = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        // bodies are padded to an even size
                        padded = {1'b0, chunk_length} + {32'd0, chunk_length[0]};
                        if ({1'b0, byte_index} + 33'd1 >= padded) begin
                            cur_phase  = PH_HEADER;
                            byte_index = '0;
                        end else begin
                            byte_index = byte_index + 1;
                        end
                    end
                    PH_DATA: begin
                        kind = KIND_PAYLOAD;
                        pb   = b;
                        if ({1'b0, byte_index} + 33'd1 >= {1'b0, chunk_length}) begin
                            last     = 1'b1;
                            finished = 1'b1;
                        end else begin
                            byte_index = byte_index + 1;
                        end
                    end
                    default: begin
                        finished = 1'b1;
                        kind     = KIND_IGNORED;
                    end
                endcase
            end
            // an error found on this byte wins over the early-end error
            if (err == ERR_NONE && beat.file_end && !finished)
                err = (cur_phase == PH_DATA || fmt_seen) ? ERR_NO_DATA : ERR_NO_FMT;
            if (err != ERR_NONE) begin
                kind     = KIND_ERROR;
                pb       = 8'd0;
                last     = 1'b0;
                finished = 1'b1;
            end
            if (finished) cur_phase = PH_DONE;
            r.item_kind     = kind;
            r.payload_byte  = pb;
            r.payload_last  = last;
            r.format_valid  = fmt_done;
            r.format_code   = fmt_format;
            r.channel_count = fmt_channels;
            r.sampling_rate = fmt_rate;
            r.sample_bits   = fmt_bits;
            r.error_code    = err;
            due_results.insert(due_results.size(), r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result beat with no byte waiting for it");
                mismatch_count++;
                return;
            end
            want = due_results.pop_front();
            check_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
            check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            check_field("payload_last", 32'(want.payload_last), 32'(got.payload_last));
            check_field("format_valid", 32'(want.format_valid), 32'(got.format_valid));
            check_field("format_code", 32'(want.format_code), 32'(got.format_code));
            check_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
            check_field("sampling_rate", want.sampling_rate, got.sampling_rate);
            check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
            check_field("error_code", 32'(want.error_code), 32'(got.error_code));
        endfunction

        function bit all_matched();
            if (due_results.size() != 0) begin
                $error("%0d result beats never arrived", due_results.size());
                mismatch_count++;
            end
            return mismatch_count == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    wavhp_in_if  in_if();
    wavhp_cfg_if cfg_if();
    wavhp_out_if out_if();

    wav_chunk_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    wav_parse_board board = new();
    logic [7:0]     file_bytes[$];
    int             bytes_sent = 0;
    bit             idle_on;
    bit             hold_off;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: check each beat, then pick ready for the next edge.
    initial begin
        t_result got;
        int      stall_left;
        stall_left = 0;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.item_kind     = out_if.item_kind;
                got.payload_byte  = out_if.payload_byte;
                got.payload_last  = out_if.payload_last;
                got.format_valid  = out_if.format_valid;
                got.format_code   = out_if.format_code;
                got.channel_count = out_if.channel_count;
                got.sampling_rate = out_if.sampling_rate;
                got.sample_bits   = out_if.sample_bits;
                got.error_code    = out_if.error_code;
                board.match_result(got);
            end
            if (stall_left > 0) stall_left--;
            else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
            out_if.ready <= !hold_off && stall_left == 0;
        end
    end

    function automatic void put_byte(logic [7:0] value);
        file_bytes.insert(file_bytes.size(), value);
    endfunction

    function automatic void push_random(int count);
        repeat (count) put_byte(8'($urandom));
    endfunction

    function automatic void push_head(logic [31:0] tag, logic [31:0] len);
        // tag goes out first character first, length little endian
        for (int i = 3; i >= 0; i--) put_byte(tag[8*i +: 8]);
        for (int i = 0; i < 4; i++) put_byte(len[8*i +: 8]);
    endfunction

    function automatic logic [31:0] junk_tag();
        logic [31:0] t;
        t = $urandom;
        if (t == TAG_FMT || t == TAG_DATA) t = t ^ 32'd1;
        return t;
    endfunction

    function automatic void push_junk(int len);
        push_head(junk_tag(), len);
        push_random(len + len % 2);
    endfunction

    function automatic void push_fmt(int len, logic [15:0] code, logic [15:0] channels,
                                     logic [31:0] rate, logic [15:0] bits);
        push_head(TAG_FMT, len);
        put_byte(code[7:0]);
        put_byte(code[15:8]);
        put_byte(channels[7:0]);
        put_byte(channels[15:8]);
        for (int i = 0; i < 4; i++) put_byte(rate[8*i +: 8]);
        push_random(6);
        put_byte(bits[7:0]);
        put_byte(bits[15:8]);
        push_random(len - 16 + len % 2);
    endfunction

    task automatic send_beat(input t_in_beat beat);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= beat.data_byte;
        in_if.file_start <= beat.file_start;
        in_if.file_end   <= beat.file_end;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        board.parse_byte(beat);
        bytes_sent++;
    endtask

    // end_at < 0 leaves the file open; the next file_start restarts the parse
    task automatic send_file(input int end_at, input bit with_start);
        t_in_beat beat;
        foreach (file_bytes[i]) begin
            beat.data_byte  = file_bytes[i];
            beat.file_start = with_start && i == 0;
            beat.file_end   = i == end_at;
            send_beat(beat);
        end
    endtask

    task automatic write_chunk_limit(input logic [3:0] value);
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.chunk_limit <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        board.set_chunk_limit(value);
    endtask

    task automatic build_random_file(output int end_at, output bit with_start);
        int          sel;
        int          n;
        logic [15:0] code;
        file_bytes.delete();
        with_start = $urandom_range(0, 19) != 0;
        sel = $urandom_range(0, 99);
        push_random(12);
        if (sel < 70) begin
            repeat ($urandom_range(0, 2)) push_junk($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) code = 16'($urandom);
            else code = $urandom_range(0, 1) ? FMT_PCM : FMT_EXTENSIBLE;
            push_fmt($urandom_range(16, 22), code, 16'($urandom), $urandom, 16'($urandom));
            // a second fmt chunk is skipped like any other
            if ($urandom_range(0, 3) == 0)
                push_fmt(16, 16'($urandom), 16'($urandom), $urandom, 16'($urandom));
            repeat ($urandom_range(0, 1)) push_junk($urandom_range(0, 5));
            n = $urandom_range(0, 24);
            push_head(TAG_DATA, n);
            push_random(n + $urandom_range(0, 3));
        end else if (sel < 78) begin
            // run of empty chunks to run into the chunk limit
            repeat ($urandom_range(0, 16)) push_head(junk_tag(), 0);
            push_fmt(16, FMT_PCM, 16'($urandom), $urandom, 16'($urandom));
            push_head(TAG_DATA, 4);
            push_random(4);
        end else if (sel < 84) begin
            push_head(TAG_DATA, $urandom_range(0, 8));
            push_random(4);
        end else if (sel < 89) begin
            push_head(TAG_FMT, $urandom_range(0, 15));
            push_random(16);
        end else if (sel < 95) begin
            // full-width lengths, cut short by the end of file
            if ($urandom_range(0, 1)) push_fmt(16, FMT_PCM, 16'($urandom), $urandom, 16'($urandom));
            push_head($urandom_range(0, 1) ? TAG_DATA : junk_tag(), $urandom);
            push_random($urandom_range(1, 10));
        end else begin
            file_bytes.delete();
            push_random($urandom_range(1, 30));
        end
        end_at = file_bytes.size() - 1;
        if ($urandom_range(0, 9) == 0) end_at = $urandom_range(0, end_at);
        else if ($urandom_range(0, 19) == 0) end_at = -1;
    endtask

    task automatic run_random_files(input int stop_at, input bit allow_idle);
        int end_at;
        bit with_start;
        while (bytes_sent < stop_at) begin
            build_random_file(end_at, with_start);
            idle_on <= allow_idle && $urandom_range(0, 3) != 0;
            send_file(end_at, with_start);
        end
    endtask

    initial begin
        in_if.valid        <= 1'b0;
        in_if.data_byte    <= 8'd0;
        in_if.file_start   <= 1'b0;
        in_if.file_end     <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.chunk_limit <= CHUNK_LIMIT_RST;
        i_rst_n            <= 1'b0;
        idle_on            <= 1'b1;
        hold_off           <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain PCM file, odd data length, payload extremes
        file_bytes.delete();
        push_random(12);
        push_fmt(16, FMT_PCM, 16'd2, 32'd44100, 16'd16);
        push_head(TAG_DATA, 3);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h5A);
        send_file(file_bytes.size() - 1, 1'b1);

        // padded junk, extensible fmt at full scale, later fmt skipped, empty data, tail ignored
        file_bytes.delete();
        push_random(12);
        push_junk(3);
        push_fmt(18, FMT_EXTENSIBLE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        push_fmt(16, 16'h0003, 16'h0000, 32'h0000_0000, 16'h0000);
        push_head(TAG_DATA, 0);
        push_random(2);
        send_file(file_bytes.size() - 1, 1'b1);

        // data before fmt
        file_bytes.delete();
        push_random(12);
        push_head(TAG_DATA, 4);
        push_random(4);
        send_file(file_bytes.size() - 1, 1'b1);

        // fmt shorter than 16
        file_bytes.delete();
        push_random(12);
        push_head(TAG_FMT, 15);
        push_random(15);
        send_file(file_bytes.size() - 1, 1'b1);

        // unsupported format code
        file_bytes.delete();
        push_random(12);
        push_fmt(16, 16'h0003, 16'd1, 32'd8000, 16'd8);
        push_head(TAG_DATA, 2);
        push_random(2);
        send_file(file_bytes.size() - 1, 1'b1);

        // end inside the descriptor
        file_bytes.delete();
        push_random(20);
        send_file(5, 1'b1);

        // end inside the data chunk
        file_bytes.delete();
        push_random(12);
        push_fmt(16, FMT_PCM, 16'd1, 32'd48000, 16'd24);
        push_head(TAG_DATA, 10);
        push_random(4);
        send_file(file_bytes.size() - 1, 1'b1);

        // one-byte file
        file_bytes.delete();
        push_random(1);
        send_file(0, 1'b1);

        write_chunk_limit(4'd15);
        fork
            begin
                repeat (20) @(posedge i_clk);
                hold_off <= 1'b1;
                repeat (64) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        run_random_files(800, 1'b1);

        write_chunk_limit(4'd1);
        run_random_files(1050, 1'b1);

        write_chunk_limit(4'($urandom_range(2, 14)));
        run_random_files(1500, 1'b1);

        // last stretch runs without idling on either side
        write_chunk_limit(4'($urandom_range(1, 15)));
        run_random_files(1850, 1'b0);

        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.all_matched())
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
